/* hdl/e2m_pkg.sv */
// ----------------------------------------------------------------------------
// e2m_pkg
// Shared types, widths and constants of the Euler angle to MRP converter.
// ----------------------------------------------------------------------------
`default_nettype none

package e2m_pkg;

    localparam int MAX_STEPS = 24;   // length of the arctangent table

    localparam int ANG_W    = 16;    // input angle, 1/64 degree
    localparam int OUT_W    = 16;    // Q3.12 result
    localparam int CX_W     = 32;    // CORDIC x/y datapath, Q30
    localparam int CZ_W     = 30;    // CORDIC angle, 2^-20 degree
    localparam int TRIG_W   = 17;    // rounded sine/cosine, Q1.15
    localparam int PROD_W   = 34;    // pair products
    localparam int TRIPLE_W = 51;    // triple products, Q45
    localparam int R_W      = 32;    // quaternion terms, Q30
    localparam int SQ_W     = 62;    // sum of squares, Q60
    localparam int SQ_N     = SQ_W / 2;
    localparam int ROOT_W   = SQ_W / 2;
    localparam int SREM_W   = ROOT_W + 3;
    localparam int DEN_W    = R_W + 1;
    localparam int QUO_W    = 17;    // quotient bits, enough to flag clipping
    localparam int DIV_W    = R_W + QUO_W + 1;

    localparam logic signed [17:0] DEG90  = 18'sd11520;
    localparam logic signed [17:0] DEG180 = 18'sd23040;
    localparam logic signed [17:0] DEG360 = 18'sd46080;

    localparam logic signed [OUT_W-1:0] OUT_MAX = 16'sh7FFF;
    localparam logic signed [OUT_W-1:0] OUT_MIN = 16'sh8000;

    typedef struct packed {
        logic signed [ANG_W-1:0] angle_x;
        logic signed [ANG_W-1:0] angle_y;
        logic signed [ANG_W-1:0] angle_z;
    } angles_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] mrp_x;
        logic signed [OUT_W-1:0] mrp_y;
        logic signed [OUT_W-1:0] mrp_z;
        logic                    saturated;
    } mrp_t;

    // atan(2^-i) in units of 2^-20 degree
    function automatic logic signed [CZ_W-1:0] atan_deg20(input int unsigned idx);
        logic signed [CZ_W-1:0] v;
        case (idx)
            0:       v = 30'sd47185920;
            1:       v = 30'sd27855475;
            2:       v = 30'sd14718068;
            3:       v = 30'sd7471121;
            4:       v = 30'sd3750058;
            5:       v = 30'sd1876857;
            6:       v = 30'sd938658;
            7:       v = 30'sd469358;
            8:       v = 30'sd234682;
            9:       v = 30'sd117342;
            10:      v = 30'sd58671;
            11:      v = 30'sd29335;
            12:      v = 30'sd14668;
            13:      v = 30'sd7334;
            14:      v = 30'sd3667;
            15:      v = 30'sd1833;
            16:      v = 30'sd917;
            17:      v = 30'sd458;
            18:      v = 30'sd229;
            19:      v = 30'sd115;
            20:      v = 30'sd57;
            21:      v = 30'sd29;
            22:      v = 30'sd14;
            23:      v = 30'sd7;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

/* hdl/e2m_stream_if.sv */
// ----------------------------------------------------------------------------
// e2m_stream_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface e2m_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hdl/euler_to_mrp_converter.sv */
// ----------------------------------------------------------------------------
// euler_to_mrp_converter
// Euler angles (x, y, z) to modified Rodrigues parameters, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   angles : sink channel, one transfer per conversion (angle_x/y/z, signed,
//            1/64 degree per LSB; any 16-bit pattern is accepted and wraps).
//   result : source channel, one transfer per input (mrp_x/y/z in signed
//            Q3.12, plus saturated when the denominator is not positive or
//            a value was clipped).
//   Pipeline: the CORDIC stages (one iteration each), the square root (one
//             result bit per stage, 31 stages) and the dividers (one
//             quotient bit per stage, 17 stages) set the depth from the
//             input transfer to result.valid.
//   Throughput: one conversion per cycle while the receiver takes results.
//   Stall: the whole pipeline holds while a result waits in the output
//          register and result.ready is low; partly filled stages keep
//          their items, nothing is dropped or repeated. A bubble in the
//          output register lets the pipeline move on.
//   Reset: clears every valid bit; no result is pending afterwards. The
//          data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module euler_to_mrp_converter #(
    parameter int TRIG_STEPS = 16
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    e2m_stream_if.sink   angles,
    e2m_stream_if.source result
);

    localparam int CX_W     = e2m_pkg::CX_W;
    localparam int CZ_W     = e2m_pkg::CZ_W;
    localparam int TRIG_W   = e2m_pkg::TRIG_W;
    localparam int PROD_W   = e2m_pkg::PROD_W;
    localparam int TRIPLE_W = e2m_pkg::TRIPLE_W;
    localparam int R_W      = e2m_pkg::R_W;
    localparam int SQ_W     = e2m_pkg::SQ_W;
    localparam int SQ_N     = e2m_pkg::SQ_N;
    localparam int ROOT_W   = e2m_pkg::ROOT_W;
    localparam int SREM_W   = e2m_pkg::SREM_W;
    localparam int DEN_W    = e2m_pkg::DEN_W;
    localparam int QUO_W    = e2m_pkg::QUO_W;
    localparam int DIV_W    = e2m_pkg::DIV_W;
    localparam int OUT_W    = e2m_pkg::OUT_W;

    // CORDIC iterations, capped at the table length
    localparam int CS = (TRIG_STEPS > e2m_pkg::MAX_STEPS) ? e2m_pkg::MAX_STEPS : TRIG_STEPS;
    // fold + CORDIC + round + 2 multiply + q30 + square + pair + sum
    // + sqrt + den + prep + divide + output
    localparam int DEPTH = CS + 1 + 1 + 2 + 1 + 1 + 1 + 1 + SQ_N + 1 + 1 + QUO_W + 1;

    // ------------------------------------------------------------------
    // Pipeline control: one valid bit per stage, global advance.
    // ------------------------------------------------------------------
    logic [DEPTH-1:0] v_reg;
    logic             adv;

    assign adv          = !v_reg[DEPTH-1] || result.ready;
    assign angles.ready = adv;
    assign result.valid = v_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[DEPTH-2:0], angles.valid};
        end
    end

    // ------------------------------------------------------------------
    // Half-angle sine/cosine, one CORDIC lane per angle.
    // Lane 0: y (c1/s1), lane 1: z (c2/s2), lane 2: x (c3/s3).
    // ------------------------------------------------------------------
    logic signed [15:0]       lane_ang [3];
    logic signed [CX_W-1:0]   cx_reg   [3][CS+1];
    logic signed [CX_W-1:0]   cy_reg   [3][CS+1];
    logic signed [CZ_W-1:0]   cz_reg   [3][CS+1];
    logic                     cneg_reg [3][CS+1];
    logic signed [TRIG_W-1:0] sin_reg  [3];
    logic signed [TRIG_W-1:0] cos_reg  [3];

    assign lane_ang[0] = angles.data.angle_y;
    assign lane_ang[1] = angles.data.angle_z;
    assign lane_ang[2] = angles.data.angle_x;

    for (genvar l = 0; l < 3; l++)
    begin : g_lane
        logic signed [17:0]     a_raw;
        logic signed [17:0]     a_wrap;
        logic signed [17:0]     a_fold;
        logic                   neg_fold;
        logic signed [CX_W-1:0] x_rnd;
        logic signed [CX_W-1:0] y_rnd;
        logic signed [CX_W-1:0] c_sel;

        // wrap the half angle into +-180, fold into +-90 (fold flips cos)
        always_comb
        begin
            a_raw    = 18'(lane_ang[l]);
            a_wrap   = a_raw;
            a_fold   = a_raw;
            neg_fold = 1'b0;
            if (a_raw > e2m_pkg::DEG180)
            begin
                a_wrap = a_raw - e2m_pkg::DEG360;
            end
            else if (a_raw < -e2m_pkg::DEG180)
            begin
                a_wrap = a_raw + e2m_pkg::DEG360;
            end
            a_fold = a_wrap;
            if (a_wrap > e2m_pkg::DEG90)
            begin
                a_fold   = e2m_pkg::DEG180 - a_wrap;
                neg_fold = 1'b1;
            end
            else if (a_wrap < -e2m_pkg::DEG90)
            begin
                a_fold   = -e2m_pkg::DEG180 - a_wrap;
                neg_fold = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                cx_reg[l][0]   <= CX_W'(32'sd536870912);
                cy_reg[l][0]   <= '0;
                cz_reg[l][0]   <= {{(CZ_W-29){a_fold[15]}}, a_fold[15:0], 13'b0};
                cneg_reg[l][0] <= neg_fold;
            end
        end

        for (genvar k = 1; k <= CS; k++)
        begin : g_iter
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    cneg_reg[l][k] <= cneg_reg[l][k-1];
                    if (!cz_reg[l][k-1][CZ_W-1])
                    begin
                        cx_reg[l][k] <= cx_reg[l][k-1] - (cy_reg[l][k-1] >>> (k-1));
                        cy_reg[l][k] <= cy_reg[l][k-1] + (cx_reg[l][k-1] >>> (k-1));
                        cz_reg[l][k] <= cz_reg[l][k-1] - e2m_pkg::atan_deg20(k-1);
                    end
                    else
                    begin
                        cx_reg[l][k] <= cx_reg[l][k-1] + (cy_reg[l][k-1] >>> (k-1));
                        cy_reg[l][k] <= cy_reg[l][k-1] - (cx_reg[l][k-1] >>> (k-1));
                        cz_reg[l][k] <= cz_reg[l][k-1] + e2m_pkg::atan_deg20(k-1);
                    end
                end
            end
        end

        // round Q30 to Q1.15, nearest, ties up
        assign x_rnd = (cx_reg[l][CS] + CX_W'(16384)) >>> 15;
        assign y_rnd = (cy_reg[l][CS] + CX_W'(16384)) >>> 15;
        assign c_sel = cneg_reg[l][CS] ? -x_rnd : x_rnd;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sin_reg[l] <= y_rnd[TRIG_W-1:0];
                cos_reg[l] <= c_sel[TRIG_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Quaternion: pair products, then triple products, then Q30.
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0]   c1c2_reg, s1s2_reg, s1c2_reg, c1s2_reg;
    logic signed [TRIG_W-1:0]   c3_reg, s3_reg;
    logic signed [TRIPLE_W-1:0] t_reg [8];
    logic signed [R_W-1:0]      r_reg [4];

    function automatic logic signed [R_W-1:0] to_q30(input logic signed [TRIPLE_W:0] v);
        logic signed [TRIPLE_W:0] t;
        t = (v + (TRIPLE_W+1)'(16384)) >>> 15;
        return t[R_W-1:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c1c2_reg <= cos_reg[0] * cos_reg[1];
            s1s2_reg <= sin_reg[0] * sin_reg[1];
            s1c2_reg <= sin_reg[0] * cos_reg[1];
            c1s2_reg <= cos_reg[0] * sin_reg[1];
            c3_reg   <= cos_reg[2];
            s3_reg   <= sin_reg[2];

            t_reg[0] <= c1c2_reg * s3_reg;
            t_reg[1] <= s1s2_reg * c3_reg;
            t_reg[2] <= s1c2_reg * c3_reg;
            t_reg[3] <= c1s2_reg * s3_reg;
            t_reg[4] <= c1s2_reg * c3_reg;
            t_reg[5] <= s1c2_reg * s3_reg;
            t_reg[6] <= c1c2_reg * c3_reg;
            t_reg[7] <= s1s2_reg * s3_reg;

            r_reg[0] <= to_q30((TRIPLE_W+1)'(t_reg[0]) + (TRIPLE_W+1)'(t_reg[1]));
            r_reg[1] <= to_q30((TRIPLE_W+1)'(t_reg[2]) + (TRIPLE_W+1)'(t_reg[3]));
            r_reg[2] <= to_q30((TRIPLE_W+1)'(t_reg[4]) - (TRIPLE_W+1)'(t_reg[5]));
            r_reg[3] <= to_q30((TRIPLE_W+1)'(t_reg[6]) - (TRIPLE_W+1)'(t_reg[7]));
        end
    end

    // ------------------------------------------------------------------
    // Sum of squares: square, pair add, final add.
    // ------------------------------------------------------------------
    logic signed [2*R_W-1:0] sq_full  [4];
    logic [SQ_W-1:0]         sqr_reg  [4];
    logic [SQ_W-1:0]         pair_reg [2];
    logic signed [R_W-1:0]   r_sq_reg [4];
    logic signed [R_W-1:0]   r_pr_reg [4];

    for (genvar q = 0; q < 4; q++)
    begin : g_square
        assign sq_full[q] = r_reg[q] * r_reg[q];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int q = 0; q < 4; q++)
            begin
                sqr_reg[q]  <= sq_full[q][SQ_W-1:0];
                r_sq_reg[q] <= r_reg[q];
                r_pr_reg[q] <= r_sq_reg[q];
            end
            pair_reg[0] <= sqr_reg[0] + sqr_reg[1];
            pair_reg[1] <= sqr_reg[2] + sqr_reg[3];
        end
    end

    // ------------------------------------------------------------------
    // Square root, one root bit per stage; index 0 holds the sum.
    // ------------------------------------------------------------------
    logic [SQ_W-1:0]       sq_op_reg   [SQ_N+1];
    logic [SREM_W-1:0]     sq_rem_reg  [SQ_N+1];
    logic [ROOT_W-1:0]     sq_root_reg [SQ_N+1];
    logic signed [R_W-1:0] sq_num_reg  [SQ_N+1][4];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_op_reg[0]   <= pair_reg[0] + pair_reg[1];
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            for (int q = 0; q < 4; q++)
            begin
                sq_num_reg[0][q] <= r_pr_reg[q];
            end
        end
    end

    for (genvar j = 1; j <= SQ_N; j++)
    begin : g_sqrt
        logic [SREM_W-1:0] cand;
        logic [SREM_W-1:0] trial;
        logic              take;

        assign cand  = {sq_rem_reg[j-1][SREM_W-3:0], sq_op_reg[j-1][SQ_W-1 -: 2]};
        assign trial = {1'b0, sq_root_reg[j-1], 2'b01};
        assign take  = cand >= trial;

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_op_reg[j]   <= {sq_op_reg[j-1][SQ_W-3:0], 2'b00};
                sq_rem_reg[j]  <= take ? cand - trial : cand;
                sq_root_reg[j] <= {sq_root_reg[j-1][ROOT_W-2:0], take};
                for (int q = 0; q < 4; q++)
                begin
                    sq_num_reg[j][q] <= sq_num_reg[j-1][q];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Denominator |r| + r4 and numerator magnitudes.
    // ------------------------------------------------------------------
    logic signed [DEN_W-1:0] den_next;
    logic signed [DEN_W-1:0] den_reg;
    logic                    dpos_reg;
    logic [R_W-1:0]          mag_reg  [3];
    logic                    neg_reg  [3];
    logic                    zero_reg [3];

    assign den_next = $signed({2'b00, sq_root_reg[SQ_N]}) + DEN_W'(sq_num_reg[SQ_N][3]);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            den_reg  <= den_next;
            dpos_reg <= den_next > 0;
            for (int q = 0; q < 3; q++)
            begin
                neg_reg[q]  <= sq_num_reg[SQ_N][q][R_W-1];
                zero_reg[q] <= sq_num_reg[SQ_N][q] == '0;
                mag_reg[q]  <= sq_num_reg[SQ_N][q][R_W-1] ? R_W'(-sq_num_reg[SQ_N][q])
                                                          : R_W'(sq_num_reg[SQ_N][q]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Rounded division (|r_i|*4096 + den/2) / den, one quotient bit per
    // stage, MSB first; index 0 is the set-up stage with the range check.
    // ------------------------------------------------------------------
    logic [R_W-1:0]   dv_den_reg  [QUO_W+1];
    logic             dv_dpos_reg [QUO_W+1];
    logic [DIV_W-1:0] dv_rem_reg  [QUO_W+1][3];
    logic [QUO_W-1:0] dv_q_reg    [QUO_W+1][3];
    logic             dv_neg_reg  [QUO_W+1][3];
    logic             dv_zero_reg [QUO_W+1][3];
    logic             dv_ovf_reg  [QUO_W+1][3];
    logic [DIV_W-1:0] dv_num      [3];
    logic [DIV_W-1:0] dv_lim;

    assign dv_lim = DIV_W'({den_reg[R_W-1:0], {QUO_W{1'b0}}});

    for (genvar q = 0; q < 3; q++)
    begin : g_dnum
        assign dv_num[q] = DIV_W'({mag_reg[q], 12'b0}) + DIV_W'(den_reg[R_W-1:1]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_den_reg[0]  <= den_reg[R_W-1:0];
            dv_dpos_reg[0] <= dpos_reg;
            for (int q = 0; q < 3; q++)
            begin
                dv_rem_reg[0][q]  <= dv_num[q];
                dv_q_reg[0][q]    <= '0;
                dv_neg_reg[0][q]  <= neg_reg[q];
                dv_zero_reg[0][q] <= zero_reg[q];
                dv_ovf_reg[0][q]  <= dv_num[q] >= dv_lim;
            end
        end
    end

    for (genvar j = 1; j <= QUO_W; j++)
    begin : g_div
        logic [DIV_W-1:0] shv;

        assign shv = DIV_W'(dv_den_reg[j-1]) << (QUO_W - j);

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_den_reg[j]  <= dv_den_reg[j-1];
                dv_dpos_reg[j] <= dv_dpos_reg[j-1];
                for (int q = 0; q < 3; q++)
                begin
                    dv_neg_reg[j][q]  <= dv_neg_reg[j-1][q];
                    dv_zero_reg[j][q] <= dv_zero_reg[j-1][q];
                    dv_ovf_reg[j][q]  <= dv_ovf_reg[j-1][q];
                    if (dv_rem_reg[j-1][q] >= shv)
                    begin
                        dv_rem_reg[j][q] <= dv_rem_reg[j-1][q] - shv;
                        dv_q_reg[j][q]   <= {dv_q_reg[j-1][q][QUO_W-2:0], 1'b1};
                    end
                    else
                    begin
                        dv_rem_reg[j][q] <= dv_rem_reg[j-1][q];
                        dv_q_reg[j][q]   <= {dv_q_reg[j-1][q][QUO_W-2:0], 1'b0};
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sign, saturation and output register.
    // ------------------------------------------------------------------
    logic signed [OUT_W-1:0] res_val [3];
    logic [2:0]              res_sat;
    e2m_pkg::mrp_t           out_reg;

    for (genvar q = 0; q < 3; q++)
    begin : g_out
        logic [QUO_W-1:0] quo;
        logic             ovf;

        assign quo = dv_q_reg[QUO_W][q];
        assign ovf = dv_ovf_reg[QUO_W][q];

        always_comb
        begin
            res_sat[q] = 1'b0;
            res_val[q] = '0;
            if (!dv_dpos_reg[QUO_W])
            begin
                res_sat[q] = 1'b1;
                if (dv_neg_reg[QUO_W][q])
                begin
                    res_val[q] = e2m_pkg::OUT_MIN;
                end
                else if (!dv_zero_reg[QUO_W][q])
                begin
                    res_val[q] = e2m_pkg::OUT_MAX;
                end
            end
            else if (!dv_neg_reg[QUO_W][q])
            begin
                if (ovf || quo > QUO_W'(32767))
                begin
                    res_sat[q] = 1'b1;
                    res_val[q] = e2m_pkg::OUT_MAX;
                end
                else
                begin
                    res_val[q] = quo[OUT_W-1:0];
                end
            end
            else
            begin
                if (ovf || quo > QUO_W'(32768))
                begin
                    res_sat[q] = 1'b1;
                    res_val[q] = e2m_pkg::OUT_MIN;
                end
                else
                begin
                    res_val[q] = OUT_W'(-quo);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg.mrp_x     <= res_val[0];
            out_reg.mrp_y     <= res_val[1];
            out_reg.mrp_z     <= res_val[2];
            out_reg.saturated <= |res_sat;
        end
    end

    assign result.data = out_reg;

endmodule

`default_nettype wire

/* bench/tb_euler_to_mrp_converter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_euler_to_mrp_converter
// Self-checking bench for the Euler angle to MRP converter.
// A directed table of angle sets is walked first, followed by random
// transfers. Every result transfer is checked field by field against an
// in-bench fixed-point predictor. Both channels idle at random; one long
// receiver hold-off fills the pipeline and one sender pause drains it.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_euler_to_mrp_converter;

    localparam int STEPS     = 16;
    localparam int LATENCY   = STEPS + 59;
    localparam int N_RANDOM  = 900;
    localparam int WDOG_MAX  = 20000;
    localparam int HOLD_LEN  = 400;
    localparam int HALF_ANG  = 23040;   // 180-degree half angle (360 degrees of input)
    localparam int QUART_ANG = 11520;
    localparam int FULL_ANG  = 46080;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #5 clk = ~clk;

    e2m_stream_if #(.payload_t(e2m_pkg::angles_t)) angles_ch ();
    e2m_stream_if #(.payload_t(e2m_pkg::mrp_t))    mrp_ch ();

    euler_to_mrp_converter #(.TRIG_STEPS(STEPS)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .angles (angles_ch.sink),
        .result (mrp_ch.source)
    );

    // Directed rows. Where has_exp is set the expected result was worked out
    // by hand and is checked against the predictor, which checks the block.
    typedef struct {
        e2m_pkg::angles_t a;
        bit               has_exp;
        e2m_pkg::mrp_t    exp;
    } row_t;

    e2m_pkg::mrp_t pending_mrp[$];
    int     errors = 0;
    int     sent = 0;
    int     got = 0;
    int     sat_seen = 0;
    int     wdog = 0;
    bit     stim_done = 1'b0;
    bit     hold_req = 1'b0;
    bit     drain_req = 1'b0;
    row_t   dir_rows[$];

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic longint asr_l(longint v, int k);
        return v >>> k;
    endfunction

    // Half-angle sine/cosine in Q1.15 via CORDIC, gain left in.
    function automatic void half_trig(input logic signed [15:0] ang,
                                      output longint s, output longint c);
        longint a;
        longint x;
        longint y;
        longint z;
        longint nx;
        longint atn;
        bit     flip;
        int     n;
        a = ang;
        x = longint'(1) << 29;
        y = 0;
        flip = 1'b0;
        n = (STEPS > e2m_pkg::MAX_STEPS) ? e2m_pkg::MAX_STEPS : STEPS;
        if (a > HALF_ANG) a -= FULL_ANG;
        if (a < -HALF_ANG) a += FULL_ANG;
        if (a > QUART_ANG) begin a = HALF_ANG - a; flip = 1'b1; end
        if (a < -QUART_ANG) begin a = -HALF_ANG - a; flip = 1'b1; end
        z = a * 8192;
        for (int i = 0; i < n; i++)
        begin
            atn = longint'(e2m_pkg::atan_deg20(i));
            if (z >= 0)
            begin
                nx = x - asr_l(y, i);
                y  = y + asr_l(x, i);
                z -= atn;
            end
            else
            begin
                nx = x + asr_l(y, i);
                y  = y - asr_l(x, i);
                z += atn;
            end
            x = nx;
        end
        x = asr_l(x + 16384, 15);
        y = asr_l(y + 16384, 15);
        c = flip ? -x : x;
        s = y;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    function automatic logic signed [15:0] q12_ratio(longint num, longint den,
                                                     inout bit clip);
        longint unsigned mag;
        if (den <= 0)
        begin
            clip = 1'b1;
            return (num > 0) ? e2m_pkg::OUT_MAX
                             : ((num < 0) ? e2m_pkg::OUT_MIN : 16'sd0);
        end
        mag = longint'(num < 0 ? -num : num) * 4096;
        mag = (mag + longint'(den) / 2) / longint'(den);
        if (num >= 0)
        begin
            if (mag > 32767) begin clip = 1'b1; return e2m_pkg::OUT_MAX; end
            return 16'(mag);
        end
        if (mag > 32768) begin clip = 1'b1; return e2m_pkg::OUT_MIN; end
        return 16'(-longint'(mag));
    endfunction

    function automatic e2m_pkg::mrp_t predict_mrp(e2m_pkg::angles_t a);
        longint c1, s1, c2, s2, c3, s3, r1, r2, r3, r4, den;
        longint unsigned sq;
        bit     clip;
        e2m_pkg::mrp_t m;
        clip = 1'b0;
        half_trig(a.angle_y, s1, c1);
        half_trig(a.angle_z, s2, c2);
        half_trig(a.angle_x, s3, c3);
        r1 = asr_l(c1 * c2 * s3 + s1 * s2 * c3 + 16384, 15);
        r2 = asr_l(s1 * c2 * c3 + c1 * s2 * s3 + 16384, 15);
        r3 = asr_l(c1 * s2 * c3 - s1 * c2 * s3 + 16384, 15);
        r4 = asr_l(c1 * c2 * c3 - s1 * s2 * s3 + 16384, 15);
        sq = r1 * r1 + r2 * r2 + r3 * r3 + r4 * r4;
        den = longint'(int_sqrt(sq)) + r4;
        m.mrp_x = q12_ratio(r1, den, clip);
        m.mrp_y = q12_ratio(r2, den, clip);
        m.mrp_z = q12_ratio(r3, den, clip);
        m.saturated = clip;
        return m;
    endfunction

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------
    function automatic e2m_pkg::angles_t rand_angles();
        e2m_pkg::angles_t a;
        // mostly in-range angles, some raw 16-bit patterns to exercise wrap
        if ($urandom_range(0, 3) == 0)
            a = e2m_pkg::angles_t'(48'({$urandom, $urandom}));
        else
        begin
            a.angle_x = 16'($signed($urandom_range(0, FULL_ANG)) - HALF_ANG);
            a.angle_y = 16'($signed($urandom_range(0, FULL_ANG)) - HALF_ANG);
            a.angle_z = 16'($signed($urandom_range(0, FULL_ANG)) - HALF_ANG);
        end
        return a;
    endfunction

    function automatic row_t mk_row(int x, int y, int z, bit h = 0,
                                    int ex = 0, int ey = 0, int ez = 0,
                                    bit es = 0);
        row_t r;
        r.a.angle_x = 16'(x);
        r.a.angle_y = 16'(y);
        r.a.angle_z = 16'(z);
        r.has_exp = h;
        r.exp.mrp_x = 16'(ex);
        r.exp.mrp_y = 16'(ey);
        r.exp.mrp_z = 16'(ez);
        r.exp.saturated = es;
        return r;
    endfunction

    // Called and left at a falling edge; valid stays high between
    // back-to-back transfers and drops only for an idle gap.
    task automatic send_angles(e2m_pkg::angles_t a, bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 17);
        if ($urandom_range(0, 3) == 0) gap = 0;   // runs with no idling
        if (gap != 0)
        begin
            angles_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        angles_ch.valid <= 1'b1;
        angles_ch.data  <= a;
        pending_mrp.push_back(predict_mrp(a));
        @(posedge clk);
        while (!angles_ch.ready) @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    initial
    begin
        e2m_pkg::mrp_t chk;
        angles_ch.valid = 1'b0;
        angles_ch.data  = '0;
        // zero rotation, half turns, the wrap limits and raw extremes
        dir_rows.push_back(mk_row(0, 0, 0, 1, 0, 0, 0, 0));
        dir_rows.push_back(mk_row(23040, 0, 0));
        dir_rows.push_back(mk_row(-23040, 0, 0));
        dir_rows.push_back(mk_row(0, 23040, 0));
        dir_rows.push_back(mk_row(0, 0, 23040));
        dir_rows.push_back(mk_row(0, 0, -23040));
        dir_rows.push_back(mk_row(11520, 11520, 11520));
        dir_rows.push_back(mk_row(-11520, -11520, -11520));
        dir_rows.push_back(mk_row(32767, 32767, 32767));
        dir_rows.push_back(mk_row(-32768, -32768, -32768));
        dir_rows.push_back(mk_row(23041, -23041, 46080 - 65536));
        dir_rows.push_back(mk_row(11521, -11521, 1));
        dir_rows.push_back(mk_row(-1, -1, -1));
        dir_rows.push_back(mk_row(23040, 23040, 23040));
        dir_rows.push_back(mk_row(21000, 0, 0));
        dir_rows.push_back(mk_row(0, -22000, 0));
        dir_rows.push_back(mk_row(0, 0, 22900));
        dir_rows.push_back(mk_row(5760, -5760, 17280));
        dir_rows.push_back(mk_row(-16384, 16384, 0));
        dir_rows.push_back(mk_row(0, 21845, -21846));

        wait (rst_n);
        @(negedge clk);
        foreach (dir_rows[i])
        begin
            if (dir_rows[i].has_exp)
            begin
                chk = predict_mrp(dir_rows[i].a);
                if (chk !== dir_rows[i].exp)
                begin
                    $display("%0t predictor row %0d: expected %p actual %p",
                             $time, i, dir_rows[i].exp, chk);
                    errors++;
                end
            end
            send_angles(dir_rows[i].a, 1'b0);
        end

        for (int n = 0; n < N_RANDOM; n++)
        begin
            // long receiver hold-off while we keep offering back to back
            if (n == 200) hold_req = 1'b1;
            send_angles(rand_angles(), n >= 200 && n < 300);
            // pause until the pipeline is fully drained
            if (n == 500)
            begin
                angles_ch.valid <= 1'b0;
                drain_req = 1'b1;
                while (pending_mrp.size() != 0) @(negedge clk);
                drain_req = 1'b0;
            end
        end
        angles_ch.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // ------------------------------------------------------------------------
    // Receiver and checker
    // ------------------------------------------------------------------------
    initial
    begin
        int gap;
        mrp_ch.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                mrp_ch.ready <= 1'b0;
                repeat (HOLD_LEN) @(negedge clk);
                hold_req = 1'b0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
            if (gap != 0)
            begin
                mrp_ch.ready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
                @(negedge clk);
            end
            mrp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!mrp_ch.valid) @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        e2m_pkg::mrp_t want;
        if (rst_n && mrp_ch.valid && mrp_ch.ready)
        begin
            got++;
            if (pending_mrp.size() == 0)
            begin
                $display("%0t unexpected transfer: expected none actual %p",
                         $time, mrp_ch.data);
                errors++;
            end
            else
            begin
                want = pending_mrp.pop_front();
                if (mrp_ch.data.saturated) sat_seen++;
                if (mrp_ch.data.mrp_x !== want.mrp_x)
                begin
                    $display("%0t mrp_x: expected %0d actual %0d", $time,
                             want.mrp_x, mrp_ch.data.mrp_x);
                    errors++;
                end
                if (mrp_ch.data.mrp_y !== want.mrp_y)
                begin
                    $display("%0t mrp_y: expected %0d actual %0d", $time,
                             want.mrp_y, mrp_ch.data.mrp_y);
                    errors++;
                end
                if (mrp_ch.data.mrp_z !== want.mrp_z)
                begin
                    $display("%0t mrp_z: expected %0d actual %0d", $time,
                             want.mrp_z, mrp_ch.data.mrp_z);
                    errors++;
                end
                if (mrp_ch.data.saturated !== want.saturated)
                begin
                    $display("%0t saturated: expected %0b actual %0b", $time,
                             want.saturated, mrp_ch.data.saturated);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Reset, watchdog and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    always @(posedge clk)
    begin
        if ((angles_ch.valid && angles_ch.ready) || (mrp_ch.valid && mrp_ch.ready))
            wdog <= 0;
        else
            wdog <= wdog + 1;
    end

    initial
    begin
        wait (rst_n);
        fork
            begin
                wait (stim_done && pending_mrp.size() == 0);
                repeat (LATENCY + 20) @(posedge clk);
            end
            wait (wdog >= WDOG_MAX);
        join_any
        if (wdog >= WDOG_MAX)
        begin
            $display("%0t watchdog expired, %0d transfers outstanding", $time,
                     pending_mrp.size());
            $display("FAIL");
        end
        else
        begin
            $display("Ran %0d conversions (%0d saturated), with stalls and drain.",
                     got, sat_seen);
            if (errors == 0)
                $display("PASS");
            else
                $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
hdl/e2m_pkg.sv
hdl/e2m_stream_if.sv
hdl/euler_to_mrp_converter.sv
bench/tb_euler_to_mrp_converter.sv
